>>> hw/rtl/lsem_pkg.sv
// ----------------------------------------------------------------------------
// lsem_pkg
// Shared widths, reset values and stage payload types of the load-scaled
// execution-time monitor.
// ----------------------------------------------------------------------------
package lsem_pkg;

    localparam int TICK_W  = 32;
    localparam int LOAD_W  = 16;
    localparam int BLK_W   = 8;
    localparam int CNT_W   = 11;

    localparam int BLOCK_COUNT_DEF     = 16;
    localparam int LOAD_FULL_SCALE_DEF = 100;
    localparam int WINDOW_CYCLES_DEF   = 10;

    localparam logic [TICK_W-1:0] PERIOD_RESET = TICK_W'(100);

    // raw period report as taken from the input channel
    typedef struct packed {
        logic              baseline_ready;
        logic [LOAD_W-1:0] load_request;
        logic [BLK_W-1:0]  block_cap;
        logic [TICK_W-1:0] wake_tick;
        logic [TICK_W-1:0] start_tick;
        logic [TICK_W-1:0] end_tick;
    } lsem_item_t;

    // per-period measurement, plus run ticks divided by the window length
    typedef struct packed {
        logic [BLK_W-1:0]  blocks;
        logic [TICK_W-1:0] run;
        logic              missed;
        logic [TICK_W-1:0] run_quot;
    } lsem_meas_t;

    // window snapshot, all zero while the window stays open
    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] average;
        logic [TICK_W-1:0] peak;
        logic [CNT_W-1:0]  misses;
    } lsem_win_t;

endpackage

>>> hw/rtl/lsem_period.sv
// ----------------------------------------------------------------------------
// lsem_period
// Per-period measurement: effective block count, run ticks, deadline check
// and the run ticks divided by the window length (quotient only).
// ----------------------------------------------------------------------------
module lsem_period
    import lsem_pkg::*;
#(
    parameter int BLOCK_COUNT     = BLOCK_COUNT_DEF,
    parameter int LOAD_FULL_SCALE = LOAD_FULL_SCALE_DEF,
    parameter int WINDOW_CYCLES   = WINDOW_CYCLES_DEF
)
(
    input  lsem_item_t        item,
    input  logic [TICK_W-1:0] period_ticks,
    output lsem_meas_t        meas
);

    // Divide by a constant through a rounded-up reciprocal: exact for every
    // dividend below 2**N when the shift is N + clog2(divisor).
    localparam int PROD_IN_W  = LOAD_W + BLK_W;
    localparam int BLK_SHIFT  = PROD_IN_W + $clog2(LOAD_FULL_SCALE);
    localparam int BLK_PROD_W = BLK_SHIFT + PROD_IN_W;
    localparam logic [63:0] BLK_POW   = 64'd1 << BLK_SHIFT;
    localparam logic [63:0] BLK_RECIP = (BLK_POW + 64'(LOAD_FULL_SCALE) - 64'd1)
                                        / 64'(LOAD_FULL_SCALE);
    localparam logic [63:0] BLK_CONST = BLK_RECIP * 64'(BLOCK_COUNT);

    localparam int AVG_SHIFT  = TICK_W + $clog2(WINDOW_CYCLES);
    localparam int AVG_PROD_W = AVG_SHIFT + TICK_W;
    localparam logic [63:0] AVG_POW   = 64'd1 << AVG_SHIFT;
    localparam logic [63:0] AVG_RECIP = (AVG_POW + 64'(WINDOW_CYCLES) - 64'd1)
                                        / 64'(WINDOW_CYCLES);

    logic [BLK_PROD_W-1:0] blk_prod;
    logic [PROD_IN_W-1:0]  blk_quot;
    logic [BLK_W-1:0]      blk_limit;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [TICK_W-1:0]     deadline;
    logic [TICK_W-1:0]     run;

    assign blk_prod  = BLK_PROD_W'(item.load_request) * BLK_PROD_W'(BLK_CONST);
    assign blk_quot  = blk_prod[BLK_SHIFT +: PROD_IN_W];
    // cap above the block count falls back to the block count
    assign blk_limit = (item.block_cap > BLK_W'(BLOCK_COUNT)) ? BLK_W'(BLOCK_COUNT)
                                                              : item.block_cap;

    assign run      = item.end_tick - item.start_tick;
    assign deadline = item.wake_tick + period_ticks;
    assign avg_prod = AVG_PROD_W'(run) * AVG_PROD_W'(AVG_RECIP);

    always_comb
    begin
        meas.run      = run;
        meas.missed   = (item.end_tick > deadline);
        meas.run_quot = avg_prod[AVG_SHIFT +: TICK_W];
        if (!item.baseline_ready)
        begin
            meas.blocks = '0;
        end
        else if (blk_quot > PROD_IN_W'(blk_limit))
        begin
            meas.blocks = blk_limit;
        end
        else
        begin
            meas.blocks = blk_quot[BLK_W-1:0];
        end
    end

endmodule

>>> hw/rtl/lsem_window.sv
// ----------------------------------------------------------------------------
// lsem_window
// Window accumulators: peak, miss count, period count and the running sum
// held as quotient and remainder of the window length, so that the average
// drops out at window close without a divider.
// ----------------------------------------------------------------------------
module lsem_window
    import lsem_pkg::*;
#(
    parameter int WINDOW_CYCLES = WINDOW_CYCLES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  lsem_meas_t meas,
    output lsem_win_t  snap
);

    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW_CYCLES);

    logic [TICK_W-1:0] peak_reg,  peak_next;
    logic [TICK_W-1:0] quot_reg,  quot_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  miss_reg,  miss_next;

    logic [CNT_W-1:0]  rem_run;
    logic [CNT_W:0]    rem_sum;
    logic              carry;
    logic [TICK_W-1:0] quot_sum;
    logic [TICK_W-1:0] peak_upd;
    logic [CNT_W-1:0]  count_upd;
    logic [CNT_W-1:0]  miss_upd;
    logic [CNT_W-1:0]  rem_upd;
    logic              close;

    // remainder of this run is below the window length, so low bits suffice
    assign rem_run   = meas.run[CNT_W-1:0] - meas.run_quot[CNT_W-1:0] * WIN_CNT;
    assign rem_sum   = {1'b0, rem_reg} + {1'b0, rem_run};
    assign carry     = (rem_sum >= {1'b0, WIN_CNT});
    assign rem_upd   = carry ? CNT_W'(rem_sum - {1'b0, WIN_CNT}) : rem_sum[CNT_W-1:0];
    assign quot_sum  = quot_reg + meas.run_quot + TICK_W'(carry);
    assign peak_upd  = (meas.run > peak_reg) ? meas.run : peak_reg;
    assign count_upd = count_reg + CNT_W'(1);
    assign miss_upd  = miss_reg + CNT_W'(meas.missed);
    assign close     = (count_upd >= WIN_CNT);

    always_comb
    begin
        snap.done    = close;
        snap.average = close ? quot_sum : '0;
        snap.peak    = close ? peak_upd : '0;
        snap.misses  = close ? miss_upd : '0;

        peak_next  = peak_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        miss_next  = miss_reg;
        if (advance)
        begin
            if (close)
            begin
                // window closed: start the next one empty
                peak_next  = '0;
                quot_next  = '0;
                rem_next   = '0;
                count_next = '0;
                miss_next  = '0;
            end
            else
            begin
                peak_next  = peak_upd;
                quot_next  = quot_sum;
                rem_next   = rem_upd;
                count_next = count_upd;
                miss_next  = miss_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            quot_reg  <= '0;
            rem_reg   <= '0;
            count_reg <= '0;
            miss_reg  <= '0;
        end
        else
        begin
            peak_reg  <= peak_next;
            quot_reg  <= quot_next;
            rem_reg   <= rem_next;
            count_reg <= count_next;
            miss_reg  <= miss_next;
        end
    end

endmodule

>>> hw/rtl/load_scaled_exec_time_monitor.sv
// A result passes the input, measurement and result registers before it is offered.
// Throughput: one period report per cycle while out_ready does not stall, set by
// the three-stage pipeline (input register, measurement register, result register).
// Reset: all stages empty, window accumulators zero, period_ticks at 100.
// ----------------------------------------------------------------------------
// load_scaled_exec_time_monitor
// Per-period block scaling, run ticks and deadline check, with window
// average, peak and miss snapshots every WINDOW_CYCLES periods.
// ----------------------------------------------------------------------------
module load_scaled_exec_time_monitor
    import lsem_pkg::*;
#(
    parameter int BLOCK_COUNT     = BLOCK_COUNT_DEF,
    parameter int LOAD_FULL_SCALE = LOAD_FULL_SCALE_DEF,
    parameter int WINDOW_CYCLES   = WINDOW_CYCLES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_wr_en,
    input  logic [TICK_W-1:0] cfg_wr_data,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              baseline_ready,
    input  logic [LOAD_W-1:0] load_request,
    input  logic [BLK_W-1:0]  block_cap,
    input  logic [TICK_W-1:0] wake_tick,
    input  logic [TICK_W-1:0] start_tick,
    input  logic [TICK_W-1:0] end_tick,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [BLK_W-1:0]  active_blocks,
    output logic [TICK_W-1:0] run_ticks,
    output logic              deadline_missed,
    output logic              window_done,
    output logic [TICK_W-1:0] window_average,
    output logic [TICK_W-1:0] window_peak,
    output logic [CNT_W-1:0]  window_misses
);

    logic [TICK_W-1:0] period_reg;
    logic              v1_reg, v2_reg, vout_reg;
    lsem_item_t        item_reg;
    lsem_meas_t        meas_reg;
    lsem_meas_t        res_meas_reg;
    lsem_win_t         res_win_reg;

    lsem_meas_t        meas;
    lsem_win_t         snap;
    logic              en1, en2, en3;

    // each stage advances when the one after it is empty or moving
    assign en3      = !vout_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    lsem_period #(
        .BLOCK_COUNT     (BLOCK_COUNT),
        .LOAD_FULL_SCALE (LOAD_FULL_SCALE),
        .WINDOW_CYCLES   (WINDOW_CYCLES)
    ) u_period (
        .item         (item_reg),
        .period_ticks (period_reg),
        .meas         (meas)
    );

    lsem_window #(
        .WINDOW_CYCLES (WINDOW_CYCLES)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (en3 && v2_reg),
        .meas    (meas_reg),
        .snap    (snap)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            vout_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                vout_reg <= v2_reg;
            end
        end
    end

    // payload stages: hold while stalled
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            item_reg.baseline_ready <= baseline_ready;
            item_reg.load_request   <= load_request;
            item_reg.block_cap      <= block_cap;
            item_reg.wake_tick      <= wake_tick;
            item_reg.start_tick     <= start_tick;
            item_reg.end_tick       <= end_tick;
        end
        if (en2)
        begin
            meas_reg <= meas;
        end
        if (en3)
        begin
            res_meas_reg <= meas_reg;
            res_win_reg  <= snap;
        end
    end

    assign out_valid        = vout_reg;
    assign active_blocks    = res_meas_reg.blocks;
    assign run_ticks        = res_meas_reg.run;
    assign deadline_missed  = res_meas_reg.missed;
    assign window_done      = res_win_reg.done;
    assign window_average   = res_win_reg.average;
    assign window_peak      = res_win_reg.peak;
    assign window_misses    = res_win_reg.misses;

endmodule
